[src/haversine_route_distance_assert.svh]
// Assertion macros for the checker file of the route distance block.
`ifndef HAVERSINE_ROUTE_DISTANCE_ASSERT_SVH
`define HAVERSINE_ROUTE_DISTANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define HRD_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("haversine route distance check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define HRD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("haversine route distance check failed");

`endif

[src/hrd_pkg.sv]
// Types, constants and the arctangent table of the route distance block.
package hrd_pkg;

    localparam int CNT_W      = 5;
    localparam int CW         = 35;
    localparam int ZW         = 32;
    localparam int MAG_W      = 35;
    localparam int OPD_W      = 36;
    localparam int MUL_STEPS  = 5;
    localparam int MB_W       = 8 * MUL_STEPS;
    localparam int ACC_W      = MAG_W + MB_W;
    localparam int SQRT_STEPS = 31;
    localparam int SQ_W       = 62;

    localparam logic signed [ZW-1:0] ANG_QUARTER = 32'sd94371840;
    localparam logic signed [ZW-1:0] ANG_HALF    = 32'sd188743680;
    localparam logic signed [ZW-1:0] ANG_FULL    = 32'sd377487360;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 35'sd652032874;
    localparam logic [30:0]          Q30_ONE     = 31'h4000_0000;
    localparam logic [27:0]          PI_OVER_90  = 28'd149922641;
    localparam logic [22:0]          LEG_MAX     = 23'h7F_FFFF;
    localparam logic [31:0]          TOTAL_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_ROT_SAVE,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_MUL_SAVE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SQRT_SAVE,
        OP_VEC_INIT,
        OP_VEC_STEP,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        JOB_DLAT,
        JOB_DLON,
        JOB_LAT1,
        JOB_LAT2,
        JOB_SH,
        JOB_SL,
        JOB_CC,
        JOB_A,
        JOB_SIN_ROOT,
        JOB_COS_ROOT,
        JOB_VEC,
        JOB_T,
        JOB_LEG
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_INIT,
        ST_ROT,
        ST_ROT_SAVE,
        ST_MUL_INIT,
        ST_MUL,
        ST_MUL_SAVE,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_SQRT_SAVE,
        ST_VEC_INIT,
        ST_VEC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        dp_op_t           op;
        job_t             job;
        logic [CNT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic route_start;
        logic out_busy;
    } dp_stat_t;

    // atan(2^-i) in degrees, scaled by 2^20 and rounded.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                5'd0:    v = 32'sd47185920;
                5'd1:    v = 32'sd27855475;
                5'd2:    v = 32'sd14718068;
                5'd3:    v = 32'sd7471121;
                5'd4:    v = 32'sd3750058;
                5'd5:    v = 32'sd1876857;
                5'd6:    v = 32'sd938658;
                5'd7:    v = 32'sd469357;
                5'd8:    v = 32'sd234682;
                5'd9:    v = 32'sd117342;
                5'd10:   v = 32'sd58671;
                5'd11:   v = 32'sd29335;
                5'd12:   v = 32'sd14668;
                5'd13:   v = 32'sd7334;
                5'd14:   v = 32'sd3667;
                5'd15:   v = 32'sd1833;
                5'd16:   v = 32'sd917;
                5'd17:   v = 32'sd458;
                5'd18:   v = 32'sd229;
                5'd19:   v = 32'sd115;
                5'd20:   v = 32'sd57;
                5'd21:   v = 32'sd29;
                5'd22:   v = 32'sd14;
                5'd23:   v = 32'sd7;
                5'd24:   v = 32'sd4;
                5'd25:   v = 32'sd2;
                5'd26:   v = 32'sd1;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

[src/hrd_ctrl.sv]
// Sequencer that steps the datapath through the haversine evaluation.
module hrd_ctrl #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output hrd_pkg::dp_cmd_t  cmd,
    input  hrd_pkg::dp_stat_t stat
);
    import hrd_pkg::*;

    localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(CORDIC_ITERATIONS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_DLAT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.job    = job_reg;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (stat.route_start)
                        state_next = ST_FINISH;
                    else
                    begin
                        state_next = ST_ROT_INIT;
                        job_next   = JOB_DLAT;
                    end
                end
            end
            ST_ROT_INIT:
            begin
                cmd.op     = OP_ROT_INIT;
                cnt_next   = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.op = OP_ROT_STEP;
                if (cnt_reg == ROT_LAST)
                    state_next = ST_ROT_SAVE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ROT_SAVE:
            begin
                cmd.op     = OP_ROT_SAVE;
                state_next = ST_ROT_INIT;
                case (job_reg)
                    JOB_DLAT: job_next = JOB_DLON;
                    JOB_DLON: job_next = JOB_LAT1;
                    JOB_LAT1: job_next = JOB_LAT2;
                    default:
                    begin
                        job_next   = JOB_SH;
                        state_next = ST_MUL_INIT;
                    end
                endcase
            end
            ST_MUL_INIT:
            begin
                cmd.op     = OP_MUL_INIT;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (cnt_reg == MUL_LAST)
                    state_next = ST_MUL_SAVE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_MUL_SAVE:
            begin
                cmd.op     = OP_MUL_SAVE;
                state_next = ST_MUL_INIT;
                case (job_reg)
                    JOB_SH: job_next = JOB_SL;
                    JOB_SL: job_next = JOB_CC;
                    JOB_CC: job_next = JOB_A;
                    JOB_A:
                    begin
                        job_next   = JOB_SIN_ROOT;
                        state_next = ST_SQRT_INIT;
                    end
                    JOB_T:  job_next = JOB_LEG;
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (cnt_reg == SQRT_LAST)
                    state_next = ST_SQRT_SAVE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQRT_SAVE:
            begin
                cmd.op = OP_SQRT_SAVE;
                if (job_reg == JOB_SIN_ROOT)
                begin
                    job_next   = JOB_COS_ROOT;
                    state_next = ST_SQRT_INIT;
                end
                else
                begin
                    job_next   = JOB_VEC;
                    state_next = ST_VEC_INIT;
                end
            end
            ST_VEC_INIT:
            begin
                cmd.op     = OP_VEC_INIT;
                cnt_next   = '0;
                state_next = ST_VEC;
            end
            ST_VEC:
            begin
                cmd.op = OP_VEC_STEP;
                if (cnt_reg == ROT_LAST)
                begin
                    job_next   = JOB_T;
                    state_next = ST_MUL_INIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[src/hrd_datapath.sv]
// Shared CORDIC stage, byte-serial multiplier, square root and route totals.
module hrd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [23:0] north_deg,
    input  logic signed [24:0] west_deg,
    input  logic               first_point,
    input  logic               cfg_valid,
    input  logic [12:0]        cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [22:0]        leg_distance,
    output logic [31:0]        route_total,
    output logic               total_saturated,
    input  hrd_pkg::dp_cmd_t   cmd,
    output hrd_pkg::dp_stat_t  stat
);
    import hrd_pkg::*;

    logic [12:0]        radius_reg;
    logic               have_prev_reg;
    logic signed [23:0] prev_n_reg, cur_n_reg;
    logic signed [24:0] prev_w_reg, cur_w_reg;
    logic               start_reg;

    logic signed [CW-1:0] rx_reg, ry_reg;
    logic signed [ZW-1:0] rz_reg;
    logic                 flip_reg;

    logic signed [CW-1:0] s1_reg, s2_reg, c1_reg, c2_reg, sh_reg, sl_reg, cc_reg;
    logic [30:0]          a_reg, rs_reg, rc_reg;

    logic [MAG_W-1:0] ma_reg;
    logic [MB_W-1:0]  mb_reg;
    logic             msign_reg;
    logic [ACC_W-1:0] acc_reg;

    logic [SQ_W-1:0] rem_reg, root_reg;
    logic [33:0]     t_reg;
    logic [22:0]     leg_reg;

    logic [31:0] total_reg;
    logic        clip_reg;
    logic        out_valid_reg;
    logic [22:0] out_leg_reg;
    logic [31:0] out_total_reg;
    logic        out_sat_reg;

    // Angle selection and reduction to [-90, 90] degrees.
    logic signed [24:0] d_lat;
    logic signed [25:0] d_lon;
    logic signed [29:0] ang_raw;
    logic signed [ZW-1:0] ang_w, ang_f;
    logic                 ang_flip;

    always_comb
    begin
        d_lat = 25'(prev_n_reg) - 25'(cur_n_reg);
        d_lon = 26'(prev_w_reg) - 26'(cur_w_reg);
        case (cmd.job)
            JOB_DLAT: ang_raw = 30'(d_lat) <<< 3;
            JOB_DLON: ang_raw = 30'(d_lon) <<< 3;
            JOB_LAT1: ang_raw = 30'(prev_n_reg) <<< 4;
            default:  ang_raw = 30'(cur_n_reg) <<< 4;
        endcase
        ang_w = ZW'(ang_raw);
        if (ang_w >= ANG_HALF)
            ang_w = ang_w - ANG_FULL;
        else if (ang_w < -ANG_HALF)
            ang_w = ang_w + ANG_FULL;
        ang_flip = 1'b0;
        ang_f    = ang_w;
        if (ang_w > ANG_QUARTER)
        begin
            ang_f    = ANG_HALF - ang_w;
            ang_flip = 1'b1;
        end
        else if (ang_w < -ANG_QUARTER)
        begin
            ang_f    = -ANG_HALF - ang_w;
            ang_flip = 1'b1;
        end
    end

    // One CORDIC micro-rotation per cycle.
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;

    always_comb
    begin
        dx = ry_reg >>> cmd.idx;
        dy = rx_reg >>> cmd.idx;
        at = atan_lut(cmd.idx);
    end

    // Multiplier operands and clamped half central angle.
    logic [26:0]           zq;
    logic signed [OPD_W-1:0] opd_a, opd_b, neg_a, neg_b;
    logic [MAG_W-1:0]      mag_a, mag_b;

    always_comb
    begin
        if (rz_reg < 0)
            zq = '0;
        else if (rz_reg > ANG_QUARTER)
            zq = 27'(ANG_QUARTER);
        else
            zq = 27'(rz_reg);
        case (cmd.job)
            JOB_SH:
            begin
                opd_a = OPD_W'(s1_reg);
                opd_b = OPD_W'(s1_reg);
            end
            JOB_SL:
            begin
                opd_a = OPD_W'(s2_reg);
                opd_b = OPD_W'(s2_reg);
            end
            JOB_CC:
            begin
                opd_a = OPD_W'(c1_reg);
                opd_b = OPD_W'(c2_reg);
            end
            JOB_A:
            begin
                opd_a = OPD_W'(cc_reg);
                opd_b = OPD_W'(sl_reg);
            end
            JOB_T:
            begin
                opd_a = OPD_W'(zq);
                opd_b = OPD_W'(PI_OVER_90);
            end
            JOB_LEG:
            begin
                opd_a = OPD_W'(t_reg);
                opd_b = OPD_W'(radius_reg);
            end
            default:
            begin
                opd_a = '0;
                opd_b = '0;
            end
        endcase
        neg_a = -opd_a;
        neg_b = -opd_b;
        mag_a = opd_a[OPD_W-1] ? MAG_W'(neg_a) : MAG_W'(opd_a);
        mag_b = opd_b[OPD_W-1] ? MAG_W'(neg_b) : MAG_W'(opd_b);
    end

    // Byte-serial partial product.
    logic [7:0]         mb_byte;
    logic [MAG_W+7:0]   pp;
    logic [ACC_W-1:0]   acc_add;

    always_comb
    begin
        mb_byte = 8'(mb_reg >> {cmd.idx, 3'b000});
        pp      = (MAG_W + 8)'(ma_reg) * (MAG_W + 8)'(mb_byte);
        acc_add = ACC_W'(pp) << {cmd.idx, 3'b000};
    end

    // Product post-processing.
    logic signed [ACC_W:0]   prod_s, q30_full;
    logic signed [CW-1:0]    q30;
    logic signed [CW+1:0]    a_sum;
    logic [30:0]             a_clamp;
    logic [ACC_W-1:0]        t_full, leg_full;
    logic [22:0]             leg_clamp;

    always_comb
    begin
        prod_s   = msign_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        q30_full = prod_s >>> 30;
        q30      = CW'(q30_full);
        a_sum    = (CW + 2)'(sh_reg) + (CW + 2)'(q30);
        if (a_sum < 0)
            a_clamp = '0;
        else if (a_sum > (CW + 2)'(Q30_ONE))
            a_clamp = Q30_ONE;
        else
            a_clamp = 31'(a_sum);
        t_full   = (acc_reg + (ACC_W'(1) << 19)) >> 20;
        leg_full = (acc_reg + (ACC_W'(1) << 23)) >> 24;
        if (leg_full > ACC_W'(LEG_MAX))
            leg_clamp = LEG_MAX;
        else
            leg_clamp = 23'(leg_full);
    end

    // Square root, two radicand bits per cycle.
    logic [SQ_W-1:0] sq_bit, sq_sum;
    logic [5:0]      sq_shift;

    always_comb
    begin
        sq_shift = 6'd60 - {cmd.idx, 1'b0};
        sq_bit   = SQ_W'(1) << sq_shift;
        sq_sum   = root_reg + sq_bit;
    end

    // Route accumulation.
    logic [32:0] total_sum;

    always_comb
    begin
        total_sum = 33'(total_reg) + 33'(leg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 13'd3959;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                radius_reg <= cfg_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == OP_FINISH)
            begin
                have_prev_reg <= 1'b1;
                out_valid_reg <= 1'b1;
                if (start_reg)
                begin
                    total_reg <= '0;
                    clip_reg  <= 1'b0;
                end
                else if (total_sum[32])
                begin
                    total_reg <= TOTAL_MAX;
                    clip_reg  <= 1'b1;
                end
                else
                    total_reg <= total_sum[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cur_n_reg <= north_deg;
                cur_w_reg <= west_deg;
                start_reg <= first_point | ~have_prev_reg;
            end
            OP_ROT_INIT:
            begin
                rx_reg   <= CORDIC_GAIN;
                ry_reg   <= '0;
                rz_reg   <= ang_f;
                flip_reg <= ang_flip;
            end
            OP_ROT_STEP:
            begin
                if (rz_reg >= 0)
                begin
                    rx_reg <= rx_reg - dx;
                    ry_reg <= ry_reg + dy;
                    rz_reg <= rz_reg - at;
                end
                else
                begin
                    rx_reg <= rx_reg + dx;
                    ry_reg <= ry_reg - dy;
                    rz_reg <= rz_reg + at;
                end
            end
            OP_ROT_SAVE:
            begin
                case (cmd.job)
                    JOB_DLAT: s1_reg <= ry_reg;
                    JOB_DLON: s2_reg <= ry_reg;
                    JOB_LAT1: c1_reg <= flip_reg ? -rx_reg : rx_reg;
                    default:  c2_reg <= flip_reg ? -rx_reg : rx_reg;
                endcase
            end
            OP_MUL_INIT:
            begin
                ma_reg    <= mag_a;
                mb_reg    <= MB_W'(mag_b);
                msign_reg <= opd_a[OPD_W-1] ^ opd_b[OPD_W-1];
                acc_reg   <= '0;
            end
            OP_MUL_STEP:
                acc_reg <= acc_reg + acc_add;
            OP_MUL_SAVE:
            begin
                case (cmd.job)
                    JOB_SH:  sh_reg  <= q30;
                    JOB_SL:  sl_reg  <= q30;
                    JOB_CC:  cc_reg  <= q30;
                    JOB_A:   a_reg   <= a_clamp;
                    JOB_T:   t_reg   <= 34'(t_full);
                    default: leg_reg <= leg_clamp;
                endcase
            end
            OP_SQRT_INIT:
            begin
                root_reg <= '0;
                if (cmd.job == JOB_SIN_ROOT)
                    rem_reg <= SQ_W'(a_reg) << 30;
                else
                    rem_reg <= SQ_W'(Q30_ONE - a_reg) << 30;
            end
            OP_SQRT_STEP:
            begin
                if (rem_reg >= sq_sum)
                begin
                    rem_reg  <= rem_reg - sq_sum;
                    root_reg <= (root_reg >> 1) + sq_bit;
                end
                else
                    root_reg <= root_reg >> 1;
            end
            OP_SQRT_SAVE:
            begin
                if (cmd.job == JOB_SIN_ROOT)
                    rs_reg <= 31'(root_reg);
                else
                    rc_reg <= 31'(root_reg);
            end
            OP_VEC_INIT:
            begin
                rx_reg <= CW'(rc_reg);
                ry_reg <= CW'(rs_reg);
                rz_reg <= '0;
            end
            OP_VEC_STEP:
            begin
                if (ry_reg > 0)
                begin
                    rx_reg <= rx_reg + dx;
                    ry_reg <= ry_reg - dy;
                    rz_reg <= rz_reg + at;
                end
                else
                begin
                    rx_reg <= rx_reg - dx;
                    ry_reg <= ry_reg + dy;
                    rz_reg <= rz_reg - at;
                end
            end
            OP_FINISH:
            begin
                prev_n_reg <= cur_n_reg;
                prev_w_reg <= cur_w_reg;
                if (start_reg)
                begin
                    out_leg_reg   <= '0;
                    out_total_reg <= '0;
                    out_sat_reg   <= 1'b0;
                end
                else
                begin
                    out_leg_reg   <= leg_reg;
                    out_total_reg <= total_sum[32] ? TOTAL_MAX : total_sum[31:0];
                    out_sat_reg   <= clip_reg | total_sum[32];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.route_start = first_point | ~have_prev_reg;
    assign stat.out_busy    = out_valid_reg & ~out_ready;
    assign out_valid        = out_valid_reg;
    assign leg_distance     = out_leg_reg;
    assign route_total      = out_total_reg;
    assign total_saturated  = out_sat_reg;

endmodule

[src/haversine_route_distance.sv]
// Top level of the haversine route distance block.
// Waypoints enter one transaction at a time on the slave stream and each
// one returns exactly one result transaction on the master stream. A
// waypoint that starts a route (tuser set, or the first since reset) gives
// a zero leg with the total cleared. Any other waypoint goes through four
// sine/cosine passes and one arctangent pass that share a single
// iterative CORDIC stage, six products through one byte-serial multiplier,
// and two square roots that resolve two radicand bits per cycle. A
// finished result waits in an output register, so the next waypoint is
// taken while the previous result is still pending.
// The earth radius register is written through the cfg channel, which is
// always ready, and should only be changed while the block is idle.
module haversine_route_distance #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // north_deg [23:0], west_deg [48:24], zero fill
    input  logic        s_tuser,   // first_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // leg_distance [22:0], route_total [54:23], zero fill
    output logic        m_tuser,   // total_saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // earth_radius_miles
);
    import hrd_pkg::*;

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [22:0] leg_distance;
    logic [31:0] route_total;

    // The controller issues one datapath command per cycle.
    hrd_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    hrd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .north_deg       ($signed(s_tdata[23:0])),
        .west_deg        ($signed(s_tdata[48:24])),
        .first_point     (s_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .leg_distance    (leg_distance),
        .route_total     (route_total),
        .total_saturated (m_tuser),
        .cmd             (cmd),
        .stat            (stat)
    );

    // The radius register accepts a write in every cycle.
    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, route_total, leg_distance};

endmodule

[src/hrd_checker.sv]
// Port-level checks of the route distance block and their binding.
module hrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);
`include "haversine_route_distance_assert.svh"

    // A stalled result transaction keeps its payload.
`HRD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The block is not ready in the cycle after it takes a waypoint.
`HRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // A saturated total always shows the maximum value.
`HRD_ASSERT_NOW(a_sat_is_max, m_tvalid && m_tuser, m_tdata[54:23] == 32'hFFFF_FFFF)

    // The padding bit of the result stays clear.
`HRD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[55] == 1'b0)

endmodule

bind haversine_route_distance hrd_checker u_hrd_checker (.*);

[tb/haversine_route_distance_test.sv]
// Self-checking stream testbench for the haversine route distance block.
`timescale 1ns / 100ps

module haversine_route_distance_test;

    localparam int ITERS = 24;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    haversine_route_distance #(.CORDIC_ITERATIONS(ITERS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [23:0] north;
        logic [24:0] west;
        logic        first;
    } waypoint_t;

    typedef struct packed {
        logic [22:0] leg;
        logic [31:0] total;
        logic        clipped;
    } distance_t;

    // Predictor state: previous waypoint, running total and radius.
    longint    prd_north, prd_west;
    bit        prd_have;
    longint    prd_total;
    bit        prd_clip;
    longint    prd_radius;

    waypoint_t pending_waypoints[$];
    distance_t expected_distances[$];

    int  send_idle_pct, recv_idle_pct;
    int  hold_off;
    int  mismatches;
    int  watchdog;
    bit  cfg_busy;

    longint atan_deg20[32] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0};

    // Arithmetic shift right rounding toward minus infinity.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_rotate(input longint ang, output longint s,
                                          output longint c);
        longint r, x, y, dx, dy;
        bit flip;
        r = ang % 64'sd377487360;
        x = 652032874;
        y = 0;
        flip = 0;
        if (r < 0) r += 377487360;
        if (r >= 188743680) r -= 377487360;
        if (r > 94371840) begin
            r = 188743680 - r;
            flip = 1;
        end
        else if (r < -94371840) begin
            r = -188743680 - r;
            flip = 1;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (r >= 0) begin
                x -= dx; y += dy; r -= atan_deg20[i];
            end
            else begin
                x += dx; y -= dy; r += atan_deg20[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint half_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_deg20[i];
            end
            else begin
                x -= dx; y += dy; z -= atan_deg20[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 94371840) z = 94371840;
        return z;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint great_circle_leg(longint n1, longint w1, longint n2,
                                                longint w2);
        longint s1, s2, c1, c2, junk, sh, sl, cc, a, z;
        longint unsigned rs, rc, t, leg;
        cordic_rotate((n1 - n2) * 8, s1, junk);
        cordic_rotate((w1 - w2) * 8, s2, junk);
        cordic_rotate(n1 * 16, junk, c1);
        cordic_rotate(n2 * 16, junk, c2);
        sh = shr_floor(s1 * s1, 30);
        sl = shr_floor(s2 * s2, 30);
        cc = shr_floor(c1 * c2, 30);
        a = sh + shr_floor(cc * sl, 30);
        if (a < 0) a = 0;
        if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
        rs = floor_root(longint'(a) << 30);
        rc = floor_root(((64'sd1 << 30) - a) << 30);
        z = half_angle(rs, rc);
        t = (longint'(z) * 64'd149922641 + (64'd1 << 19)) >> 20;
        leg = (t * prd_radius + (64'd1 << 23)) >> 24;
        return (leg > 64'h7FFFFF) ? 64'h7FFFFF : leg;
    endfunction

    function automatic distance_t predict_distance(waypoint_t wp);
        distance_t d;
        longint n, w, leg;
        n = longint'($signed(wp.north));
        w = longint'($signed(wp.west));
        leg = 0;
        if (wp.first || !prd_have) begin
            prd_total = 0;
            prd_clip = 0;
        end
        else begin
            leg = great_circle_leg(prd_north, prd_west, n, w);
            prd_total += leg;
            if (prd_total > 64'hFFFFFFFF) begin
                prd_total = 64'hFFFFFFFF;
                prd_clip = 1;
            end
        end
        prd_north = n;
        prd_west = w;
        prd_have = 1;
        d.leg = leg[22:0];
        d.total = prd_total[31:0];
        d.clipped = prd_clip;
        return d;
    endfunction

    // Queue a waypoint and its expected result together.
    task automatic queue_waypoint(int north, int west, bit first);
        waypoint_t wp;
        distance_t want;
        wp.north = north[23:0];
        wp.west = west[24:0];
        wp.first = first;
        want = predict_distance(wp);
        pending_waypoints = {pending_waypoints, wp};
        expected_distances = {expected_distances, want};
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Driver: offers queued waypoints, idling at the current sender rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_waypoints.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1;
                s_tdata  <= {7'b0, pending_waypoints[0].west, pending_waypoints[0].north};
                s_tuser  <= pending_waypoints[0].first;
                void'(pending_waypoints.pop_front());
            end
            else
                s_tvalid <= 0;
        end
    end

    // Receiver readiness, with a long hold-off whenever hold_off is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compares every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        distance_t got, want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid)
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (m_tvalid && m_tready)
            begin
                got.leg = m_tdata[22:0];
                got.total = m_tdata[54:23];
                got.clipped = m_tuser;
                if (expected_distances.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result transaction: %p", got);
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display(
                                "mismatch: expected leg/total/sat %0d/%0d/%0b, got %0d/%0d/%0b",
                                want.leg, want.total, want.clipped,
                                got.leg, got.total, got.clipped);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("haversine_route_distance_test: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_waypoints.size() > 0 || expected_distances.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Radius write through the cfg channel, only with the block idle.
    task automatic write_radius(int radius);
        cfg_valid <= 1;
        cfg_data  <= radius[12:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        prd_radius = radius;
        @(posedge clk);
    endtask

    function automatic int rand_signed(int lim);
        return $urandom_range(2 * lim) - lim;
    endfunction

    // Mostly proper routes with realistic coordinates; some full-width noise.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
        begin
            int mode;
            mode = $urandom_range(99);
            if (mode < 8)
                queue_waypoint($urandom, $urandom, $urandom_range(1));
            else
                queue_waypoint(rand_signed(5898240), rand_signed(11796480),
                               ($urandom_range(15) == 0));
        end
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
        mismatches = 0;
        watchdog = 0;
        prd_have = 0; prd_north = 0; prd_west = 0; prd_total = 0; prd_clip = 0;
        prd_radius = 3959;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part at the reset radius: first waypoint without the flag,
        // field extremes, antipodes, out-of-range wrap and restarts.
        queue_waypoint(0, 0, 0);
        queue_waypoint(5898240, 11796480, 0);
        queue_waypoint(-5898240, -11796480, 0);
        queue_waypoint(5898240, 0, 0);
        queue_waypoint(-5898240, 11796480, 0);
        queue_waypoint(0, 11796480, 1);
        queue_waypoint(0, -11796480, 0);
        queue_waypoint(-8388608, -16777216, 0);
        queue_waypoint(8388607, 16777215, 0);
        queue_waypoint(1, 1, 0);
        queue_waypoint(1, 1, 0);
        queue_waypoint(2696000, -5400000, 1);
        queue_waypoint(2700000, -5390000, 0);
        wait_drained();

        // Largest radius with long legs drives the total towards clipping.
        write_radius(8191);
        queue_waypoint(0, 0, 1);
        for (int i = 0; i < 12; i++)
            queue_waypoint((i % 2) ? 5898240 : -5898240, (i % 2) ? 11796480 : 0, 0);
        wait_drained();

        write_radius(0);
        queue_waypoint(0, 0, 0);
        queue_waypoint(5898240, 11796480, 0);
        wait_drained();

        write_radius(1);
        send_idle_pct = 36;
        recv_idle_pct = 46;
        queue_random(560);
        wait_drained();

        write_radius(3959);
        send_idle_pct = 46;
        recv_idle_pct = 36;
        queue_random(560);
        // Long receiver hold-off while waypoints keep coming.
        hold_off <= 3000;
        wait_drained();

        write_radius($urandom_range(8191, 1));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(560);
        wait_drained();

        if (mismatches == 0)
            $display("haversine_route_distance_test: done, clean");
        else
            $display("haversine_route_distance_test: done, errors");
        $finish;
    end

endmodule
